>>> rtl/ws2812_pixel_spi_encoder_macros.svh
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder assertion macros
// Guarded assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WS2812_PIXEL_SPI_ENCODER_MACROS_SVH
`define WS2812_PIXEL_SPI_ENCODER_MACROS_SVH

`ifndef SYNTH

// Check that the consequent holds in the same cycle as the antecedent
`define WPSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpse assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define WPSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpse assertion failed");

`else

`define WPSE_ASSERT_SAME(label, clk, rst, ante, cons)
`define WPSE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/wpse_pkg.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder package
// Transaction types, register codes, constants and the brightness curve.
// ----------------------------------------------------------------------------
package wpse_pkg;

   // Widths and sizes
   localparam int PixelWidth       = 24;
   localparam int SymbolsPerPixel  = 24;
   localparam int BitsLeftWidth    = 5;
   localparam int CsrIndexWidth    = 2;
   localparam int CsrDataWidth     = 16;
   localparam int QueueDepthDefault = 2;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] RegPixelCount = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegOneSymbol  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegZeroSymbol = 2'd2;

   // Register reset values
   localparam logic [15:0] PixelCountReset = 16'hFFFF;
   localparam logic [7:0]  OneSymbolReset  = 8'h7E;
   localparam logic [7:0]  ZeroSymbolReset = 8'h70;

   // Scaling modes
   localparam logic [1:0] ModeLinear = 2'd1;
   localparam logic [1:0] ModeCurve  = 2'd2;

   typedef struct packed {
      logic [15:0] pixel_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  scale_mode;
      logic [7:0]  level;
   } req_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] one_symbol;
      logic [7:0] zero_symbol;
   } symbol_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Perceived brightness curve, indexed by the top nibble of the level
   function automatic logic [7:0] brightness_curve(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'd0;
         4'd1:    val = 8'd1;
         4'd2:    val = 8'd2;
         4'd3:    val = 8'd3;
         4'd4:    val = 8'd4;
         4'd5:    val = 8'd6;
         4'd6:    val = 8'd8;
         4'd7:    val = 8'd12;
         4'd8:    val = 8'd23;
         4'd9:    val = 8'd36;
         4'd10:   val = 8'd48;
         4'd11:   val = 8'd70;
         4'd12:   val = 8'd95;
         4'd13:   val = 8'd135;
         4'd14:   val = 8'd190;
         default: val = 8'd255;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/wpse_front.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder front end
// Accepts pixels, drops those beyond the chain, scales and packs G:R:B.
// ----------------------------------------------------------------------------
module wpse_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  wpse_pkg::req_type           req_data,
   input  logic [15:0]                 pixel_count,
   input  wpse_pkg::queue_status_type  q_status,
   output logic                        q_push,
   output logic [wpse_pkg::PixelWidth-1:0] q_wdata
);
   import wpse_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [PixelWidth-1:0] word_ff;
   logic [PixelWidth-1:0] word_in;
   logic                  advance;
   logic                  accept;
   logic                  in_chain;
   logic                  scaled;
   logic [7:0]            factor;
   logic [15:0]           prod_r;
   logic [15:0]           prod_g;
   logic [15:0]           prod_b;

   // Stage moves on when empty or when the queue takes its word
   assign advance  = !valid_ff || !q_status.full;
   assign req_full = !advance;
   assign accept   = req_push && advance;
   assign in_chain = req_data.pixel_index < pixel_count;

   // Pick the scale factor and scale each channel
   always_comb begin
      scaled = (req_data.scale_mode == ModeLinear) || (req_data.scale_mode == ModeCurve);
      factor = (req_data.scale_mode == ModeCurve) ?
               brightness_curve(req_data.level[7:4]) : req_data.level;
      prod_r = 16'(req_data.red)   * 16'(factor);
      prod_g = 16'(req_data.green) * 16'(factor);
      prod_b = 16'(req_data.blue)  * 16'(factor);
      if (scaled) begin
         word_in = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
      end else begin
         word_in = {req_data.green, req_data.red, req_data.blue};
      end
   end

   // Keep only pixels inside the chain
   always_comb begin
      if (advance) begin
         valid_in = accept && in_chain;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the packed word until the queue takes it
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign q_push  = valid_ff && !q_status.full;
   assign q_wdata = word_ff;

endmodule

>>> rtl/wpse_queue.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder pixel queue
// Short FIFO of packed pixel words between front end and serialiser.
// ----------------------------------------------------------------------------
module wpse_queue #(
   parameter int QueueDepth = wpse_pkg::QueueDepthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_push,
   input  logic [wpse_pkg::PixelWidth-1:0] q_wdata,
   input  logic                            q_pop,
   output logic [wpse_pkg::PixelWidth-1:0] q_rdata,
   output wpse_pkg::queue_status_type      q_status,
   output logic [$clog2(QueueDepth+1)-1:0] q_count
);
   import wpse_pkg::*;

   localparam int AddrWidth  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   logic [PixelWidth-1:0] entry_ff [QueueDepth];
   logic [AddrWidth-1:0]  wr_ptr_ff;
   logic [AddrWidth-1:0]  wr_ptr_in;
   logic [AddrWidth-1:0]  rd_ptr_ff;
   logic [AddrWidth-1:0]  rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign q_status.full  = count_ff == CountWidth'(QueueDepth);
   assign q_status.empty = count_ff == '0;
   assign do_push = q_push && !q_status.full;
   assign do_pop  = q_pop && !q_status.empty;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   assign q_rdata = entry_ff[rd_ptr_ff];
   assign q_count = count_ff;

endmodule

>>> rtl/wpse_serial.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder serialiser
// Shifts each pixel word out MSB first, one SPI symbol byte per cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
module wpse_serial (
   input  logic                               clock,
   input  logic                               reset,
   input  wpse_pkg::queue_status_type         q_status,
   input  logic [wpse_pkg::PixelWidth-1:0]    q_rdata,
   output logic                               q_pop,
   input  wpse_pkg::symbol_cfg_type           symbols,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output wpse_pkg::rsp_type                  rsp_data,
   output logic [wpse_pkg::BitsLeftWidth-1:0] bits_left
);
   import wpse_pkg::*;

   logic                     out_valid_ff;
   rsp_type                  out_ff;
   rsp_type                  out_in;
   logic [PixelWidth-1:0]    shift_ff;
   logic [PixelWidth-1:0]    shift_in;
   logic [BitsLeftWidth-1:0] bits_left_ff;
   logic [BitsLeftWidth-1:0] bits_left_in;
   logic                     out_free;
   logic                     have_work;
   logic                     emit;
   logic                     data_bit;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign have_work = bits_left_ff != '0;
   assign emit      = out_free && (have_work || !q_status.empty);
   assign q_pop     = out_free && !have_work && !q_status.empty;

   // Take the next bit from the shifter, or load a fresh word
   always_comb begin
      if (have_work) begin
         data_bit     = shift_ff[PixelWidth-1];
         shift_in     = {shift_ff[PixelWidth-2:0], 1'b0};
         bits_left_in = bits_left_ff - 1'b1;
      end else begin
         data_bit     = q_rdata[PixelWidth-1];
         shift_in     = {q_rdata[PixelWidth-2:0], 1'b0};
         bits_left_in = BitsLeftWidth'(SymbolsPerPixel - 1);
      end
      out_in.spi_byte = data_bit ? symbols.one_symbol : symbols.zero_symbol;
      out_in.last     = have_work && (bits_left_ff == BitsLeftWidth'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         bits_left_ff <= '0;
      end else begin
         if (emit) begin
            out_valid_ff <= 1'b1;
            bits_left_ff <= bits_left_in;
         end else if (out_free) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the shifter and the output symbol unless a new symbol leaves
   always_ff @(posedge clock) begin
      if (emit) begin
         shift_ff <= shift_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign bits_left = bits_left_ff;

endmodule

>>> rtl/ws2812_pixel_spi_encoder.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder
// Scales RGB pixels and turns each into 24 SPI symbol bytes, GRB, MSB first.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_push / req_full    req_data  (req_type)
//   rsp      out        rsp_pop / rsp_empty    rsp_data  (rsp_type)
//   csr      in         csr_write              csr_index, csr_wdata
//
// A pixel in the chain occupies the serialiser for 24 symbols, one symbol per
// cycle while rsp is not stalled; the serialiser sets the sustained pixel rate.
// The first symbol passes the front-end register, queue and output register.
// A pixel beyond the chain is accepted and gives no symbols.
// Synchronous reset empties the queue and restores register defaults.
// A stalled rsp side fills the queue, then raises req_full.
// ----------------------------------------------------------------------------
module ws2812_pixel_spi_encoder #(
   parameter int QueueDepth = wpse_pkg::QueueDepthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  wpse_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output wpse_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [wpse_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [wpse_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import wpse_pkg::*;

   `include "ws2812_pixel_spi_encoder_macros.svh"

   localparam int CountWidth = $clog2(QueueDepth + 1);

   logic [15:0]              pixel_count_ff;
   symbol_cfg_type           symbols_ff;
   queue_status_type         q_status;
   logic                     q_push;
   logic                     q_pop;
   logic [PixelWidth-1:0]    q_wdata;
   logic [PixelWidth-1:0]    q_rdata;
   logic [CountWidth-1:0]    q_count;
   logic [BitsLeftWidth-1:0] bits_left;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff         <= PixelCountReset;
         symbols_ff.one_symbol  <= OneSymbolReset;
         symbols_ff.zero_symbol <= ZeroSymbolReset;
      end else if (csr_write) begin
         unique case (csr_index)
            RegPixelCount: pixel_count_ff         <= csr_wdata;
            RegOneSymbol:  symbols_ff.one_symbol  <= csr_wdata[7:0];
            RegZeroSymbol: symbols_ff.zero_symbol <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   wpse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .pixel_count (pixel_count_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   wpse_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_wdata  (q_wdata),
      .q_pop    (q_pop),
      .q_rdata  (q_rdata),
      .q_status (q_status),
      .q_count  (q_count)
   );

   wpse_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .symbols   (symbols_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .bits_left (bits_left)
   );

   // Symbol counter stays within one pixel
   `WPSE_ASSERT_SAME(a_bits_left_range, clock, reset, 1'b1, bits_left <= BitsLeftWidth'(SymbolsPerPixel - 1))

   // Queue never holds more than its depth
   `WPSE_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, q_count <= CountWidth'(QueueDepth))

   // A marked symbol on the output means the pixel is fully shifted out
   `WPSE_ASSERT_SAME(a_last_done, clock, reset, !rsp_empty && rsp_data.last, bits_left == '0)

   // A word is only taken from the queue between pixels
   `WPSE_ASSERT_NEXT(a_load_start, clock, reset, q_pop, bits_left == BitsLeftWidth'(SymbolsPerPixel - 1))

endmodule

>>> tb/ws2812_pixel_spi_encoder_checker.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder checker
// Watches the pixel, symbol and register channels, predicts the symbol
// stream of every accepted pixel and compares each popped symbol in order.
// ----------------------------------------------------------------------------
module ws2812_pixel_spi_encoder_checker
   import wpse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_full,
   input  req_type                  req_data,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output int                       fail_count,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Perceived brightness steps, entry 0 on the right
   localparam logic [15:0][7:0] LevelCurve = {
      8'd255, 8'd190, 8'd135, 8'd95, 8'd70, 8'd48, 8'd36, 8'd23,
      8'd12,  8'd8,   8'd6,   8'd4,  8'd3,  8'd2,  8'd1,  8'd0
   };

   // Shadow registers and the stream of symbols still owed
   logic [15:0] chain_len;
   logic [7:0]  sym_one;
   logic [7:0]  sym_zero;
   logic [23:0] grb_word;
   rsp_type     expected_symbols[$];

   function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] f);
      logic [15:0] prod;
      prod = 16'(c) * 16'(f);
      return prod[15:8];
   endfunction

   // Scale a pixel in the chain as its mode asks and queue its 24 symbols, GRB, MSB first
   function automatic void predict_symbols(input req_type px);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] factor;
      rsp_type    sym;
      r = px.red;
      g = px.green;
      b = px.blue;
      if (px.pixel_index >= chain_len) begin
         return;
      end
      if (px.scale_mode == ModeLinear || px.scale_mode == ModeCurve) begin
         factor = (px.scale_mode == ModeCurve) ? LevelCurve[px.level[7:4]] : px.level;
         r = scale_channel(r, factor);
         g = scale_channel(g, factor);
         b = scale_channel(b, factor);
      end
      grb_word = {g, r, b};
      for (int k = 0; k < SymbolsPerPixel; k++) begin
         sym.spi_byte = grb_word[23-k] ? sym_one : sym_zero;
         sym.last     = (k == SymbolsPerPixel - 1);
         expected_symbols.push_back(sym);
      end
   endfunction

   // Track registers, predict on each pixel transaction, check each symbol transaction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         chain_len = PixelCountReset;
         sym_one   = OneSymbolReset;
         sym_zero  = ZeroSymbolReset;
         grb_word  = '0;
         expected_symbols.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               RegPixelCount: chain_len = csr_wdata;
               RegOneSymbol:  sym_one   = csr_wdata[7:0];
               RegZeroSymbol: sym_zero  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            predict_symbols(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected symbol, got byte %02h last %0b",
                        $time, rsp_data.spi_byte, rsp_data.last);
               fail_count++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_data.spi_byte !== want.spi_byte) begin
                  $display("%0t: spi_byte expected %02h got %02h",
                           $time, want.spi_byte, rsp_data.spi_byte);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %0b got %0b",
                           $time, want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
      pending <= expected_symbols.size();
   end

endmodule

>>> tb/ws2812_pixel_spi_encoder_test.sv
// ----------------------------------------------------------------------------
// WS2812 pixel SPI encoder testbench
// Drives directed and random pixels through several register settings with
// random idling on both channels; the checker predicts and compares symbols.
// ----------------------------------------------------------------------------
module ws2812_pixel_spi_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wpse_pkg::*;

   localparam logic [1:0]               ModePass  = 2'd0;
   localparam logic [1:0]               ModeSpare = 2'd3;
   localparam logic [CsrIndexWidth-1:0] RegUnused = 2'd3;
   localparam int                       WatchdogLimit = 2000;
   localparam int                       PixelsPerPhase = 40;
   localparam int                       SettleCycles = 8;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   req_type                  req_data = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;
   int                       fail_count;
   int                       pending;
   int                       idle_cycles = 0;
   bit                       steady = 1'b0;
   logic [15:0]              chain_len = PixelCountReset;

   ws2812_pixel_spi_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ws2812_pixel_spi_encoder_checker encoder_check (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Pop side: stall about one cycle in five, never during a steady stretch
   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(99) >= 19);
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_type make_pixel(input logic [15:0] idx, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b,
                                          input logic [1:0] mode, input logic [7:0] level);
      req_type px;
      px.pixel_index = idx;
      px.red         = r;
      px.green       = g;
      px.blue        = b;
      px.scale_mode  = mode;
      px.level       = level;
      return px;
   endfunction

   // Offer one pixel, idling first at random, and hold it until taken
   task automatic push_pixel(input req_type px);
      while (!steady && $urandom_range(99) < 19) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_full);
   endtask

   // Hold off until every owed symbol has left and the pipeline has settled
   task automatic drain;
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all three registers; junk in the upper byte of the symbol writes
   task automatic set_registers(input logic [15:0] count, input logic [7:0] one,
                                input logic [7:0] zero);
      write_reg(RegPixelCount, count);
      write_reg(RegOneSymbol, {8'($urandom_range(255)), one});
      write_reg(RegZeroSymbol, {8'($urandom_range(255)), zero});
      csr_write <= 1'b0;
      chain_len = count;
   endtask

   // Random pixel, mostly inside the chain, the last LED of it favoured
   function automatic req_type random_pixel;
      logic [15:0] idx;
      if (chain_len != 0 && $urandom_range(99) < 85) begin
         idx = ($urandom_range(4) == 0) ? chain_len - 16'd1
                                        : 16'($urandom_range(int'(chain_len) - 1, 0));
      end else begin
         idx = 16'($urandom_range(65535, int'(chain_len)));
      end
      return make_pixel(idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 2'($urandom_range(3)),
                        8'($urandom_range(255)));
   endfunction

   initial begin
      req_type px;
      int      kept;
      logic [15:0] count;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, colour extremes, every mode, level edges
      push_pixel(make_pixel(16'd0, 8'h00, 8'h00, 8'h00, ModePass, 8'h00));
      push_pixel(make_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF, ModePass, 8'hFF));
      push_pixel(make_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF, ModePass, 8'h00));
      push_pixel(make_pixel(16'hFFFE, 8'hA5, 8'h5A, 8'hC3, ModePass, 8'h00));
      push_pixel(make_pixel(16'h5555, 8'h81, 8'h3C, 8'h7E, ModePass, 8'hFF));
      push_pixel(make_pixel(16'hAAAA, 8'hFF, 8'hFF, 8'hFF, ModeLinear, 8'h00));
      push_pixel(make_pixel(16'd1, 8'hFF, 8'hFF, 8'hFF, ModeLinear, 8'hFF));
      push_pixel(make_pixel(16'd2, 8'h80, 8'hC0, 8'h01, ModeLinear, 8'h80));
      push_pixel(make_pixel(16'd3, 8'hFF, 8'hFF, 8'hFF, ModeCurve, 8'h0F));
      push_pixel(make_pixel(16'd4, 8'hFF, 8'hFF, 8'hFF, ModeCurve, 8'h1F));
      push_pixel(make_pixel(16'd5, 8'hFF, 8'h80, 8'h7F, ModeCurve, 8'h8C));
      push_pixel(make_pixel(16'd6, 8'hFF, 8'hFF, 8'hFF, ModeCurve, 8'hF0));
      push_pixel(make_pixel(16'd7, 8'hFF, 8'hFF, 8'hFF, ModeCurve, 8'hFF));
      push_pixel(make_pixel(16'd8, 8'h12, 8'h34, 8'h56, ModeSpare, 8'h40));
      push_pixel(make_pixel(16'd9, 8'hF0, 8'h0F, 8'hAA, ModeSpare, 8'h00));

      // Empty chain drops everything; all-zero one symbol, all-one zero symbol
      drain();
      set_registers(16'd0, 8'h00, 8'hFF);
      push_pixel(make_pixel(16'd0, 8'hFF, 8'h00, 8'h55, ModePass, 8'h00));
      push_pixel(make_pixel(16'd5, 8'h11, 8'h22, 8'h33, ModeLinear, 8'hFF));

      // Single LED chain with swapped symbol extremes
      drain();
      set_registers(16'd1, 8'hFF, 8'h00);
      push_pixel(make_pixel(16'd0, 8'hC3, 8'h3C, 8'h99, ModePass, 8'h00));
      push_pixel(make_pixel(16'd1, 8'hFF, 8'hFF, 8'hFF, ModePass, 8'h00));
      push_pixel(make_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF, ModeCurve, 8'hA0));

      // Random phases, each under fresh register settings
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0:       count = 16'hFFFF;
            1:       count = 16'($urandom_range(40, 2));
            2:       count = 16'($urandom_range(65535, 1));
            3:       count = 16'($urandom_range(4000, 200));
            default: count = 16'd1;
         endcase
         if (phase == 2) begin
            write_reg(RegUnused, 16'($urandom_range(65535)));
         end
         set_registers(count, 8'($urandom_range(255)), 8'($urandom_range(255)));
         steady = (phase == 3);
         kept = 0;
         while (kept < PixelsPerPhase) begin
            px = random_pixel();
            if (px.pixel_index < chain_len) begin
               kept++;
            end
            push_pixel(px);
            // Let the symbol stream run dry once mid-phase
            if (phase == 2 && kept == PixelsPerPhase / 2) begin
               drain();
            end
         end
         steady = 1'b0;
      end

      drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
